@@ rtl/core/orlb_pkg.sv @@
// ----------------------------------------------------------------------------
// orlb_pkg: shared types and constants of the overwrite ring log buffer
// Ring size, pointer type, action codes and the control and status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package orlb_pkg;

  localparam int unsigned LOG_SIZE = 64;
  localparam int unsigned PTR_W    = $clog2(LOG_SIZE);
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned BOOT_W   = 32;
  localparam int unsigned ACT_W    = 2;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [BOOT_W-1:0] boot_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_FLUSH = 2'd1,
    ACT_CLEAN = 2'd2,
    ACT_BOOT  = 2'd3
  } action_e;

  // Commands from the controller to the datapath for one cycle.
  typedef struct packed {
    logic put;
    logic clean;
    logic boot;
    logic flush_start;
    logic flush_adv;
    logic emit_status;
    logic emit_char;
    logic emit_eol;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic in_use;
    logic empty;
    logic flush_last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic  char_valid;
    char_t char_out;
    logic  line_end;
    logic  last;
    logic  pending;
    boot_t boot_tally;
  } result_t;

  function automatic ptr_t ring_next(ptr_t p);
    ptr_t n;
    if (p == ptr_t'(LOG_SIZE - 1)) begin
      n = '0;
    end else begin
      n = p + ptr_t'(1);
    end
    return n;
  endfunction

endpackage

@@ rtl/core/orlb_if.sv @@
// ----------------------------------------------------------------------------
// orlb_if: valid/ready channels of the overwrite ring log buffer
// One interface for the action channel and one for the result channel.
// ----------------------------------------------------------------------------
interface orlb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_in;

  modport source (output valid, output action, output char_in, input ready);
  modport sink   (input valid, input action, input char_in, output ready);
endinterface

interface orlb_out_if;
  logic        valid;
  logic        ready;
  logic        char_valid;
  logic [7:0]  char_out;
  logic        line_end;
  logic        last;
  logic        pending;
  logic [31:0] boot_tally;

  modport source (output valid, output char_valid, output char_out, output line_end,
                  output last, output pending, output boot_tally, input ready);
  modport sink   (input valid, input char_valid, input char_out, input line_end,
                  input last, input pending, input boot_tally, output ready);
endinterface

@@ rtl/core/orlb_ram.sv @@
// ----------------------------------------------------------------------------
// orlb_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module orlb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/orlb_ctrl.sv @@
// ----------------------------------------------------------------------------
// orlb_ctrl: controller of the overwrite ring log buffer
// Decodes accepted actions and sequences the replay of a flush.
// ----------------------------------------------------------------------------
module orlb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_action_i,
  output logic                 in_ready_o,
  input  orlb_pkg::dp_status_t status_i,
  output orlb_pkg::dp_cmd_t    cmd_o
);
  import orlb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FLUSH = 3'b010,
    ST_EOL   = 3'b100
  } state_e;

  state_e  state_q, state_d;
  logic    accept;
  action_e act;

  assign act        = action_e'(in_action_i);
  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_PUT: begin
              cmd_o.put         = 1'b1;
              cmd_o.emit_status = 1'b1;
            end
            ACT_FLUSH: begin
              if (!status_i.in_use) begin
                cmd_o.emit_status = 1'b1;
              end else if (status_i.empty) begin
                cmd_o.emit_eol = 1'b1;
              end else begin
                cmd_o.flush_start = 1'b1;
                state_d           = ST_FLUSH;
              end
            end
            ACT_CLEAN: begin
              cmd_o.clean       = 1'b1;
              cmd_o.emit_status = 1'b1;
            end
            ACT_BOOT: begin
              cmd_o.boot        = 1'b1;
              cmd_o.emit_status = 1'b1;
            end
            default: begin
              cmd_o.emit_status = 1'b1;
            end
          endcase
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.emit_char = 1'b1;
          cmd_o.flush_adv = 1'b1;
          if (status_i.flush_last) begin
            state_d = ST_EOL;
          end
        end
      end
      ST_EOL: begin
        if (status_i.out_free) begin
          cmd_o.emit_eol = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // No new action is taken while a replay is in progress.
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("input ready while a flush is in progress");

  // A replay always finishes with the line-end beat.
  a_flush_to_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && status_i.out_free && status_i.flush_last) |=>
      (state_q == ST_EOL))
    else $error("flush did not close with a line-end beat");

  // Only one kind of result is loaded in a cycle.
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.emit_status, cmd_o.emit_char, cmd_o.emit_eol}))
    else $error("more than one result loaded in one cycle");

endmodule

@@ rtl/core/orlb_dp.sv @@
// ----------------------------------------------------------------------------
// orlb_dp: datapath of the overwrite ring log buffer
// Holds the pointers, the boot count, the text RAM and the result register.
// ----------------------------------------------------------------------------
module orlb_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  orlb_pkg::dp_cmd_t    cmd_i,
  input  logic [7:0]           char_in_i,
  input  logic                 out_ready_i,
  output orlb_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  output orlb_pkg::result_t    result_o
);
  import orlb_pkg::*;

  logic    in_use_q, in_use_d;
  boot_t   boots_q, boots_d;
  ptr_t    wp_q, wp_d;
  ptr_t    rp_q, rp_d;
  ptr_t    fp_q, fp_d;
  logic    out_valid_q, out_valid_d;
  result_t result_q, result_d;
  ptr_t    put_wp, put_rp, put_wp_next;
  char_t   rdata;
  logic    out_free;

  // A put on an unused log starts from empty pointers.
  assign put_wp      = in_use_q ? wp_q : '0;
  assign put_rp      = in_use_q ? rp_q : '0;
  assign put_wp_next = ring_next(put_wp);

  always_comb begin
    in_use_d = in_use_q;
    boots_d  = boots_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    fp_d     = fp_q;
    if (cmd_i.put) begin
      if (!in_use_q) begin
        boots_d = '0;
      end
      in_use_d = 1'b1;
      wp_d     = put_wp_next;
      rp_d     = (put_rp == put_wp_next) ? ring_next(put_rp) : put_rp;
    end
    if (cmd_i.clean && in_use_q) begin
      wp_d = '0;
      rp_d = '0;
    end
    if (cmd_i.boot) begin
      if (in_use_q) begin
        boots_d = boots_q + boot_t'(1);
      end else begin
        in_use_d = 1'b1;
        boots_d  = '0;
        wp_d     = '0;
        rp_d     = '0;
      end
    end
    if (cmd_i.flush_start) begin
      fp_d = rp_q;
    end else if (cmd_i.flush_adv) begin
      fp_d = ring_next(fp_q);
    end
  end

  // The read address follows the next replay pointer, so the registered read
  // data always holds the byte at the current replay pointer.
  orlb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (LOG_SIZE)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.put),
    .waddr_i (put_wp),
    .wdata_i (char_in_i),
    .raddr_i (fp_d),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    result_d            = result_q;
    result_d.pending    = in_use_d && (wp_d != rp_d);
    result_d.boot_tally = boots_d;
    result_d.char_valid = cmd_i.emit_char;
    result_d.char_out   = cmd_i.emit_char ? rdata : '0;
    result_d.line_end   = cmd_i.emit_eol;
    result_d.last       = cmd_i.emit_eol || cmd_i.emit_status;
    if (cmd_i.emit_status || cmd_i.emit_char || cmd_i.emit_eol) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= 1'b0;
      boots_q     <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      fp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_use_q    <= in_use_d;
      boots_q     <= boots_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      fp_q        <= fp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_status || cmd_i.emit_char || cmd_i.emit_eol) begin
      result_q <= result_d;
    end
  end

  assign status_o.in_use     = in_use_q;
  assign status_o.empty      = (rp_q == wp_q);
  assign status_o.flush_last = (ring_next(fp_q) == wp_q);
  assign status_o.out_free   = out_free;
  assign out_valid_o         = out_valid_q;
  assign result_o            = result_q;

endmodule

@@ rtl/core/overwrite_ring_log_buffer.sv @@
// ----------------------------------------------------------------------------
// overwrite_ring_log_buffer: character trace log in an overwrite-oldest ring
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
// Actions arrive on in_i (put, flush, clean, bootup) and results leave on
// out_o, both valid/ready channels; a beat moves when valid and ready are high.
// Put, clean and bootup give one status beat in the cycle after acceptance
// and can be taken one per cycle while the receiver takes each beat, since the
// next action is accepted as the previous result leaves the output register.
// A flush on a non-empty log replays the held bytes oldest first, one beat
// per cycle from the text RAM while the receiver takes each beat, then a
// line-end beat, sequenced by the controller; no action is accepted meanwhile.
// Every beat reports pending and the boot count after its action.
// Reset clears the pointers, the boot count, the in-use flag and output valid;
// result data and the text RAM are not cleared, and the RAM needs no clearing.
// When the receiver stalls, the output register holds its beat and in_i
// ready drops until the beat is taken.
// ----------------------------------------------------------------------------
module overwrite_ring_log_buffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  orlb_in_if.sink    in_i,
  orlb_out_if.source out_o
);
  import orlb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    result;
  logic       out_valid;

  orlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  orlb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .char_in_i   (in_i.char_in),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (out_valid),
    .result_o    (result)
  );

  assign out_o.valid      = out_valid;
  assign out_o.char_valid = result.char_valid;
  assign out_o.char_out   = result.char_out;
  assign out_o.line_end   = result.line_end;
  assign out_o.last       = result.last;
  assign out_o.pending    = result.pending;
  assign out_o.boot_tally = result.boot_tally;

  // Actions other than flush produce their final beat in the next cycle.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.action != ACT_FLUSH)) |=>
      (out_o.valid && out_o.last && !out_o.char_valid))
    else $error("non-flush action did not yield one final status beat");

  // The line-end beat is always the final one of its flush.
  a_eol_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.line_end) |-> (out_o.last && !out_o.char_valid))
    else $error("line-end beat not marked final");

  // A replayed byte is never the final beat.
  a_char_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.char_valid) |-> !out_o.last)
    else $error("replayed byte marked final");

endmodule
